// File: sv/mwrm_pkg.sv
`timescale 1ns / 1ps

package mwrm_pkg;

    localparam int STAMP_W   = 32;
    localparam int DIFF_W    = 32;
    localparam int SUM_OUT_W = 42;
    localparam int RATE_W    = 64;
    localparam int SEC_W     = 12;
    localparam int DIV_BITS  = 4;
    localparam int NUM_WIN   = 3;
    localparam int WIN_W     = 2;

    localparam logic [SUM_OUT_W-1:0] SUM_MAX = '1;

    typedef logic [WIN_W-1:0] win_t;

    localparam win_t WIN_SHORT = 2'd0;
    localparam win_t WIN_MID   = 2'd1;
    localparam win_t WIN_LONG  = 2'd2;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [DIFF_W-1:0]  diff;
    } sample_t;

    typedef struct packed {
        logic start;
        win_t win;
    } div_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_OVF_RD,
        ST_OVF_CHK,
        ST_APPEND,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    // window length in milliseconds
    function automatic logic [STAMP_W-1:0] win_ms(input win_t w);
        case (w)
            WIN_SHORT: win_ms = 32'd180000;
            WIN_MID:   win_ms = 32'd1800000;
            WIN_LONG:  win_ms = 32'd3600000;
            default:   win_ms = 32'd3600000;
        endcase
    endfunction

    // window length in seconds, divisor of the rate
    function automatic logic [SEC_W-1:0] win_sec(input win_t w);
        case (w)
            WIN_SHORT: win_sec = 12'd180;
            WIN_MID:   win_sec = 12'd1800;
            WIN_LONG:  win_sec = 12'd3600;
            default:   win_sec = 12'd3600;
        endcase
    endfunction

endpackage

// File: sv/mwrm_ifs.sv
`timescale 1ns / 1ps

interface mwrm_sample_if;
    import mwrm_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] sample_time_ms;
    logic [DIFF_W-1:0]  difficulty;

    modport source (output valid, output sample_time_ms, output difficulty, input ready);
    modport sink   (input valid, input sample_time_ms, input difficulty, output ready);
endinterface

interface mwrm_result_if;
    import mwrm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SUM_OUT_W-1:0] sum_short;
    logic [SUM_OUT_W-1:0] sum_mid;
    logic [SUM_OUT_W-1:0] sum_long;
    logic [RATE_W-1:0]    rate_short;
    logic [RATE_W-1:0]    rate_mid;
    logic [RATE_W-1:0]    rate_long;
    logic                 store_overflow;

    modport source (
        output valid, output sum_short, output sum_mid, output sum_long,
        output rate_short, output rate_mid, output rate_long, output store_overflow,
        input ready
    );
    modport sink (
        input valid, input sum_short, input sum_mid, input sum_long,
        input rate_short, input rate_mid, input rate_long, input store_overflow,
        output ready
    );
endinterface

// File: sv/mwrm_store.sv
`timescale 1ns / 1ps

module mwrm_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  mwrm_pkg::sample_t wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output mwrm_pkg::sample_t rd_data
);
    import mwrm_pkg::*;

    sample_t sample_mem [DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sample_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= sample_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/mwrm_div.sv
`timescale 1ns / 1ps

module mwrm_div #(
    parameter int SUM_W = 42
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mwrm_pkg::div_ctl_t          ctl,
    input  logic [SUM_W-1:0]            sum,
    output logic                        done,
    output logic [mwrm_pkg::RATE_W-1:0] quot
);
    import mwrm_pkg::*;

    localparam int HI_W   = SUM_W - 32;
    localparam int CMP_W  = HI_W + SEC_W;
    localparam int STEPS  = RATE_W / DIV_BITS;
    localparam int STEP_W = $clog2(STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [SEC_W-1:0]  rem_reg;
    logic [RATE_W-1:0] shift_reg;

    logic [HI_W-1:0]   hi;
    logic [SEC_W-1:0]  sec_in;
    logic              sat;
    logic [SEC_W-1:0]  rem_next;
    logic [RATE_W-1:0] shift_next;

    assign hi     = sum[SUM_W-1:32];
    assign sec_in = win_sec(ctl.win);
    // quotient would not fit in 64 bits
    assign sat    = CMP_W'(hi) >= CMP_W'(sec_in);

    // several restoring steps per cycle on a remainder below the divisor
    always_comb
    begin
        logic [SEC_W:0] trial;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial      = {rem_next, shift_next[RATE_W-1]};
            shift_next = {shift_next[RATE_W-2:0], 1'b0};
            if (trial >= {1'b0, sec_reg})
            begin
                trial         = trial - {1'b0, sec_reg};
                shift_next[0] = 1'b1;
            end
            rem_next = trial[SEC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                if (sat)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(STEPS - 1);
                end
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            sec_reg <= sec_in;
            rem_reg <= SEC_W'(hi);
            if (sat)
            begin
                shift_reg <= '1;
            end
            else
            begin
                shift_reg <= {sum[31:0], 32'd0};
            end
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

    assign done = done_reg;
    assign quot = shift_reg;

endmodule

// File: sv/multi_window_rate_meter_unit.sv
// multi window rate meter
//
// samples (sink): one word is a millisecond timestamp and a difficulty. the
// sample is appended to one circular store shared by three windows of 3, 30
// and 60 minutes. results (source): one word per sample with the three
// window sums (saturating at 42 bits), the three rates sum*2^32/seconds
// (saturating at 64 bits) and a flag that the oldest entry was pushed out
// because the store was full.
//
// one sample at a time: ready is high only while the sequencer is idle, so a
// new sample is taken only once the previous one is through. every age check
// is a store read then a compare, the sums go through one shared add/subtract
// unit, and each rate goes through the shared divider that retires 4 quotient
// bits a cycle, or skips the division steps when the rate saturates.
//
// reset clears pointers, counts, sums and the sequencer; the store itself
// is not cleared, entries are only read once written. a finished result sits
// in the output register while the receiver stalls; the next sample is
// still accepted and processed, then waits until that register is free.
`timescale 1ns / 1ps

module multi_window_rate_meter_unit #(
    parameter int SAMPLE_DEPTH = 1024
) (
    input logic          clk,
    input logic          rst_n,
    mwrm_sample_if.sink  samples,
    mwrm_result_if.source results
);
    import mwrm_pkg::*;

    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    // widest sum the store can hold, never narrower than the output field
    localparam int RAW_W = 32 + $clog2(SAMPLE_DEPTH);
    localparam int SUM_W = (RAW_W > SUM_OUT_W) ? RAW_W : SUM_OUT_W;

    // sequencer and window state
    state_t             state_reg, state_next;
    win_t               win_reg, win_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [DIFF_W-1:0]  diff_reg, diff_next;
    logic               flag_reg, flag_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [AW-1:0]      head_reg [NUM_WIN];
    logic [AW-1:0]      head_next [NUM_WIN];
    logic [CNT_W-1:0]   cnt_reg [NUM_WIN];
    logic [CNT_W-1:0]   cnt_next [NUM_WIN];
    logic [SUM_W-1:0]   sum_reg [NUM_WIN];
    logic [SUM_W-1:0]   sum_next [NUM_WIN];
    logic [RATE_W-1:0]  rate_reg [NUM_WIN];
    logic [RATE_W-1:0]  rate_next [NUM_WIN];

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [SUM_OUT_W-1:0] out_sum_reg [NUM_WIN];
    logic [RATE_W-1:0]    out_rate_reg [NUM_WIN];
    logic                 out_flag_reg;

    // store port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    sample_t       wr_data;
    sample_t       rd_data;

    // shared add/subtract unit on the current window's sum
    logic             alu_sub;
    logic [SUM_W-1:0] alu_b;
    logic [SUM_W-1:0] alu_res;

    // divider
    div_ctl_t          div_ctl;
    logic              div_done;
    logic [RATE_W-1:0] div_quot;

    logic [STAMP_W-1:0] age;
    logic               expired;
    logic               cur_full;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        adv = (p == AW'(SAMPLE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SUM_OUT_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
        sat_sum = (s > SUM_W'(SUM_MAX)) ? SUM_MAX : s[SUM_OUT_W-1:0];
    endfunction

    mwrm_store #(
        .DEPTH (SAMPLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mwrm_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sum   (sum_reg[win_reg]),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign wr_data  = '{stamp: now_reg, diff: diff_reg};
    // wrapping age of the oldest entry of the current window
    assign age      = now_reg - rd_data.stamp;
    assign expired  = age > win_ms(win_reg);
    assign cur_full = cnt_reg[win_reg] == CNT_W'(SAMPLE_DEPTH);
    assign alu_res  = alu_sub ? (sum_reg[win_reg] - alu_b) : (sum_reg[win_reg] + alu_b);

    assign samples.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        now_next       = now_reg;
        diff_next      = diff_reg;
        flag_next      = flag_reg;
        wp_next        = wp_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        rate_next      = rate_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg[win_reg];
        wr_en          = 1'b0;
        alu_sub        = 1'b0;
        alu_b          = SUM_W'(diff_reg);
        div_ctl.start  = 1'b0;
        div_ctl.win    = win_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    now_next   = samples.sample_time_ms;
                    diff_next  = samples.difficulty;
                    win_next   = WIN_SHORT;
                    flag_next  = 1'b0;
                    state_next = ST_EXP_RD;
                end
            end

            // fetch the oldest entry of the window, or move on when empty
            ST_EXP_RD:
            begin
                if (cnt_reg[win_reg] == '0)
                begin
                    if (win_reg == WIN_LONG)
                    begin
                        win_next   = WIN_SHORT;
                        state_next = ST_OVF_RD;
                    end
                    else
                    begin
                        win_next = win_reg + 1'b1;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EXP_CHK;
                end
            end

            ST_EXP_CHK:
            begin
                state_next = ST_EXP_RD;
                if (expired)
                begin
                    alu_sub            = 1'b1;
                    alu_b              = SUM_W'(rd_data.diff);
                    sum_next[win_reg]  = alu_res;
                    head_next[win_reg] = adv(head_reg[win_reg]);
                    cnt_next[win_reg]  = cnt_reg[win_reg] - 1'b1;
                end
                else if (win_reg == WIN_LONG)
                begin
                    win_next   = WIN_SHORT;
                    state_next = ST_OVF_RD;
                end
                else
                begin
                    win_next = win_reg + 1'b1;
                end
            end

            // any full window has its head at the write pointer
            ST_OVF_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = wp_reg;
                state_next = ST_OVF_CHK;
            end

            ST_OVF_CHK:
            begin
                if (cur_full)
                begin
                    alu_sub            = 1'b1;
                    alu_b              = SUM_W'(rd_data.diff);
                    sum_next[win_reg]  = alu_res;
                    head_next[win_reg] = adv(head_reg[win_reg]);
                    cnt_next[win_reg]  = cnt_reg[win_reg] - 1'b1;
                    flag_next          = 1'b1;
                end
                if (win_reg == WIN_LONG)
                begin
                    win_next   = WIN_SHORT;
                    state_next = ST_APPEND;
                end
                else
                begin
                    win_next = win_reg + 1'b1;
                end
            end

            ST_APPEND:
            begin
                sum_next[win_reg] = alu_res;
                cnt_next[win_reg] = cnt_reg[win_reg] + 1'b1;
                if (win_reg == WIN_SHORT)
                begin
                    wr_en   = 1'b1;
                    wp_next = adv(wp_reg);
                end
                if (win_reg == WIN_LONG)
                begin
                    win_next   = WIN_SHORT;
                    state_next = ST_DIV_START;
                end
                else
                begin
                    win_next = win_reg + 1'b1;
                end
            end

            ST_DIV_START:
            begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    rate_next[win_reg] = div_quot;
                    if (win_reg == WIN_LONG)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        win_next   = win_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end

            // hand over once the output register is free
            ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= WIN_SHORT;
            flag_reg      <= 1'b0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < NUM_WIN; w++)
            begin
                head_reg[w] <= '0;
                cnt_reg[w]  <= '0;
                sum_reg[w]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            flag_reg      <= flag_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        diff_reg <= diff_next;
        rate_reg <= rate_next;
        if (out_load)
        begin
            out_flag_reg <= flag_reg;
            for (int w = 0; w < NUM_WIN; w++)
            begin
                out_sum_reg[w]  <= sat_sum(sum_reg[w]);
                out_rate_reg[w] <= rate_reg[w];
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.sum_short      = out_sum_reg[WIN_SHORT];
    assign results.sum_mid        = out_sum_reg[WIN_MID];
    assign results.sum_long       = out_sum_reg[WIN_LONG];
    assign results.rate_short     = out_rate_reg[WIN_SHORT];
    assign results.rate_mid       = out_rate_reg[WIN_MID];
    assign results.rate_long      = out_rate_reg[WIN_LONG];
    assign results.store_overflow = out_flag_reg;

`ifndef ASSERT_OFF
    // a full long window always starts at the oldest stored entry
    a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[WIN_LONG] == CNT_W'(SAMPLE_DEPTH)) |-> (head_reg[WIN_LONG] == wp_reg))
        else $error("full long window head is not at the write pointer");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[WIN_SHORT] <= CNT_W'(SAMPLE_DEPTH))
        else $error("short window count beyond store depth");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_exp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXP_CHK) |-> (cnt_reg[win_reg] != '0))
        else $error("age check on an empty window");

    a_hold_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !results.ready)
        |=> (state_reg == ST_FINISH))
        else $error("result overwrote an output word not yet taken");
`endif

endmodule
